@@ rtl/core/sot_pkg.sv @@
// ---------------------------------------------------------------------------
// sot_pkg: shared types for the shape overlap test
// Shape-pair kind codes and the flag bundle passed down the pipeline.
// ---------------------------------------------------------------------------
package sot_pkg;

  typedef enum logic [2:0] {
    KIND_BOX_BOX       = 3'd0,
    KIND_CIRCLE_CIRCLE = 3'd1,
    KIND_BOX_CIRCLE    = 3'd2,
    KIND_POINT_BOX     = 3'd3,
    KIND_POINT_CIRCLE  = 3'd4
  } sot_kind_t;

  // bit positions in the over-radius flags
  localparam int unsigned OVR_X0 = 0;
  localparam int unsigned OVR_X1 = 1;
  localparam int unsigned OVR_Y0 = 2;
  localparam int unsigned OVR_Y1 = 3;

  typedef struct packed {
    sot_kind_t  kind;
    logic       direct_hit; // box-box, point-box, box-circle band test
    logic       band;       // circle centre inside an edge band of the box
    logic [3:0] over;       // axis distance already beyond the radius
  } sot_flags_t;

endpackage

@@ rtl/core/sot_geom.sv @@
// ---------------------------------------------------------------------------
// sot_geom: edge compares, distances and hit-point midpoints
// Two register stages: differences and box compares, then magnitudes,
// grown-box test and midpoint sums.
// ---------------------------------------------------------------------------
module sot_geom #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          en1,
  input  logic                          en2,
  input  logic [2:0]                    in_kind,
  input  logic signed [COORD_BITS-1:0]  in_a_left,
  input  logic signed [COORD_BITS-1:0]  in_a_top,
  input  logic signed [COORD_BITS-1:0]  in_a_right,
  input  logic signed [COORD_BITS-1:0]  in_a_bottom,
  input  logic [COORD_BITS-2:0]         in_a_radius,
  input  logic signed [COORD_BITS-1:0]  in_b_left,
  input  logic signed [COORD_BITS-1:0]  in_b_top,
  input  logic signed [COORD_BITS-1:0]  in_b_right,
  input  logic signed [COORD_BITS-1:0]  in_b_bottom,
  input  logic [COORD_BITS-2:0]         in_b_radius,
  output logic [COORD_BITS-1:0]         mag_x0,
  output logic [COORD_BITS-1:0]         mag_x1,
  output logic [COORD_BITS-1:0]         mag_y0,
  output logic [COORD_BITS-1:0]         mag_y1,
  output logic [COORD_BITS-1:0]         radius,
  output sot_pkg::sot_flags_t           flags,
  output logic [COORD_BITS-1:0]         mid_x,
  output logic [COORD_BITS-1:0]         mid_y
);

  localparam int CB = COORD_BITS;
  localparam int W1 = COORD_BITS + 1;

  // stage 1 registers
  sot_pkg::sot_kind_t   s1_kind_r;
  logic                 s1_pre_hit_r;
  logic                 s1_band_r;
  logic signed [W1-1:0] s1_dx0_r, s1_dx1_r, s1_dy0_r, s1_dy1_r;
  logic [CB-1:0]        s1_rad_r;
  logic signed [W1-1:0] s1_blm_r, s1_blp_r, s1_btm_r, s1_btp_r;
  logic signed [CB-1:0] s1_al_r, s1_at_r, s1_ar_r, s1_ab_r, s1_bl_r, s1_bt_r;
  logic signed [CB-1:0] s1_mx_r, s1_mnx_r, s1_my_r, s1_mny_r;

  // stage 1 next values
  sot_pkg::sot_kind_t   s1_kind_nxt;
  logic                 s1_pre_hit_nxt;
  logic                 s1_band_nxt;
  logic signed [W1-1:0] al_e, at_e, ar_e, ab_e, bl_e, bt_e, rb_e;
  logic [CB-1:0]        s1_rad_nxt;
  logic                 bb_hit, pb_hit;

  always_comb begin
    s1_kind_nxt = sot_pkg::sot_kind_t'(in_kind);
    al_e = $signed({in_a_left[CB-1], in_a_left});
    at_e = $signed({in_a_top[CB-1], in_a_top});
    ar_e = $signed({in_a_right[CB-1], in_a_right});
    ab_e = $signed({in_a_bottom[CB-1], in_a_bottom});
    bl_e = $signed({in_b_left[CB-1], in_b_left});
    bt_e = $signed({in_b_top[CB-1], in_b_top});
    rb_e = $signed({2'b00, in_b_radius});
    if (s1_kind_nxt == sot_pkg::KIND_CIRCLE_CIRCLE) begin
      s1_rad_nxt = {1'b0, in_a_radius} + {1'b0, in_b_radius};
    end else begin
      s1_rad_nxt = {1'b0, in_b_radius};
    end
    bb_hit = !((in_a_left > in_b_right) || (in_a_top > in_b_bottom) ||
               (in_a_right < in_b_left) || (in_a_bottom < in_b_top));
    pb_hit = !((in_b_left > in_a_left) || (in_b_top > in_a_top) ||
               (in_b_right < in_a_left) || (in_b_bottom < in_a_top));
    s1_pre_hit_nxt = (s1_kind_nxt == sot_pkg::KIND_BOX_BOX) ? bb_hit : pb_hit;
    s1_band_nxt = ((in_a_left <= in_b_left) && (in_b_left <= in_a_right)) ||
                  ((in_a_top <= in_b_top) && (in_b_top <= in_a_bottom));
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_kind_r    <= s1_kind_nxt;
      s1_pre_hit_r <= s1_pre_hit_nxt;
      s1_band_r    <= s1_band_nxt;
      s1_dx0_r     <= bl_e - al_e;
      s1_dx1_r     <= bl_e - ar_e;
      s1_dy0_r     <= bt_e - at_e;
      s1_dy1_r     <= bt_e - ab_e;
      s1_rad_r     <= s1_rad_nxt;
      s1_blm_r     <= bl_e - rb_e;
      s1_blp_r     <= bl_e + rb_e;
      s1_btm_r     <= bt_e - rb_e;
      s1_btp_r     <= bt_e + rb_e;
      s1_al_r      <= in_a_left;
      s1_at_r      <= in_a_top;
      s1_ar_r      <= in_a_right;
      s1_ab_r      <= in_a_bottom;
      s1_bl_r      <= in_b_left;
      s1_bt_r      <= in_b_top;
      s1_mx_r      <= (in_a_left > in_b_left) ? in_a_left : in_b_left;
      s1_mnx_r     <= (in_a_right < in_b_right) ? in_a_right : in_b_right;
      s1_my_r      <= (in_a_top > in_b_top) ? in_a_top : in_b_top;
      s1_mny_r     <= (in_a_bottom < in_b_bottom) ? in_a_bottom : in_b_bottom;
    end
  end

  // stage 2: magnitudes, grown-box test, midpoint sums
  logic [W1-1:0]        ax0, ax1, ay0, ay1, rad_e;
  logic signed [W1-1:0] s1_al_e, s1_at_e, s1_ar_e, s1_ab_e, s1_bl_e, s1_bt_e;
  logic signed [W1-1:0] px, qx, py, qy;
  logic signed [W1:0]   sum_x, sum_y;
  logic                 grown_hit;
  sot_pkg::sot_flags_t  flags_nxt;

  always_comb begin
    ax0 = s1_dx0_r[W1-1] ? W1'(-s1_dx0_r) : W1'(s1_dx0_r);
    ax1 = s1_dx1_r[W1-1] ? W1'(-s1_dx1_r) : W1'(s1_dx1_r);
    ay0 = s1_dy0_r[W1-1] ? W1'(-s1_dy0_r) : W1'(s1_dy0_r);
    ay1 = s1_dy1_r[W1-1] ? W1'(-s1_dy1_r) : W1'(s1_dy1_r);
    rad_e = {1'b0, s1_rad_r};
    s1_al_e = $signed({s1_al_r[CB-1], s1_al_r});
    s1_at_e = $signed({s1_at_r[CB-1], s1_at_r});
    s1_ar_e = $signed({s1_ar_r[CB-1], s1_ar_r});
    s1_ab_e = $signed({s1_ab_r[CB-1], s1_ab_r});
    s1_bl_e = $signed({s1_bl_r[CB-1], s1_bl_r});
    s1_bt_e = $signed({s1_bt_r[CB-1], s1_bt_r});
    grown_hit = !((s1_al_e > s1_blp_r) || (s1_at_e > s1_btp_r) ||
                  (s1_ar_e < s1_blm_r) || (s1_ab_e < s1_btm_r));

    unique case (s1_kind_r)
      sot_pkg::KIND_BOX_BOX: begin
        px = $signed({s1_mx_r[CB-1], s1_mx_r});
        qx = $signed({s1_mnx_r[CB-1], s1_mnx_r});
        py = $signed({s1_my_r[CB-1], s1_my_r});
        qy = $signed({s1_mny_r[CB-1], s1_mny_r});
      end
      sot_pkg::KIND_CIRCLE_CIRCLE: begin
        px = s1_al_e;
        qx = s1_bl_e;
        py = s1_at_e;
        qy = s1_bt_e;
      end
      sot_pkg::KIND_BOX_CIRCLE: begin
        px = (s1_al_e > s1_blm_r) ? s1_al_e : s1_blm_r;
        qx = (s1_ar_e < s1_blp_r) ? s1_ar_e : s1_blp_r;
        py = (s1_at_e > s1_btm_r) ? s1_at_e : s1_btm_r;
        qy = (s1_ab_e < s1_btp_r) ? s1_ab_e : s1_btp_r;
      end
      default: begin
        // point kinds: twice the point halves back to the point
        px = s1_al_e;
        qx = s1_al_e;
        py = s1_at_e;
        qy = s1_at_e;
      end
    endcase
    sum_x = $signed({px[W1-1], px}) + $signed({qx[W1-1], qx});
    sum_y = $signed({py[W1-1], py}) + $signed({qy[W1-1], qy});

    flags_nxt.kind = s1_kind_r;
    flags_nxt.direct_hit = (s1_kind_r == sot_pkg::KIND_BOX_CIRCLE) ? grown_hit
                                                                   : s1_pre_hit_r;
    flags_nxt.band = s1_band_r;
    flags_nxt.over[sot_pkg::OVR_X0] = ax0 > rad_e;
    flags_nxt.over[sot_pkg::OVR_X1] = ax1 > rad_e;
    flags_nxt.over[sot_pkg::OVR_Y0] = ay0 > rad_e;
    flags_nxt.over[sot_pkg::OVR_Y1] = ay1 > rad_e;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      mag_x0 <= ax0[CB-1:0];
      mag_x1 <= ax1[CB-1:0];
      mag_y0 <= ay0[CB-1:0];
      mag_y1 <= ay1[CB-1:0];
      radius <= s1_rad_r;
      flags  <= flags_nxt;
      mid_x  <= sum_x[CB:1];
      mid_y  <= sum_y[CB:1];
    end
  end

endmodule

@@ rtl/core/sot_square.sv @@
// ---------------------------------------------------------------------------
// sot_square: squaring stage
// Squares the four axis distances and the radius, one register stage.
// ---------------------------------------------------------------------------
module sot_square #(
  parameter int COORD_BITS = 24
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [COORD_BITS-1:0]     mag_x0,
  input  logic [COORD_BITS-1:0]     mag_x1,
  input  logic [COORD_BITS-1:0]     mag_y0,
  input  logic [COORD_BITS-1:0]     mag_y1,
  input  logic [COORD_BITS-1:0]     radius,
  input  sot_pkg::sot_flags_t       flags_in,
  input  logic [COORD_BITS-1:0]     mid_x_in,
  input  logic [COORD_BITS-1:0]     mid_y_in,
  output logic [2*COORD_BITS-1:0]   sq_x0,
  output logic [2*COORD_BITS-1:0]   sq_x1,
  output logic [2*COORD_BITS-1:0]   sq_y0,
  output logic [2*COORD_BITS-1:0]   sq_y1,
  output logic [2*COORD_BITS-1:0]   sq_rad,
  output sot_pkg::sot_flags_t       flags_out,
  output logic [COORD_BITS-1:0]     mid_x_out,
  output logic [COORD_BITS-1:0]     mid_y_out
);

  localparam int SW = 2 * COORD_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x0     <= SW'(mag_x0) * SW'(mag_x0);
      sq_x1     <= SW'(mag_x1) * SW'(mag_x1);
      sq_y0     <= SW'(mag_y0) * SW'(mag_y0);
      sq_y1     <= SW'(mag_y1) * SW'(mag_y1);
      sq_rad    <= SW'(radius) * SW'(radius);
      flags_out <= flags_in;
      mid_x_out <= mid_x_in;
      mid_y_out <= mid_y_in;
    end
  end

endmodule

@@ rtl/core/sot_decide.sv @@
// ---------------------------------------------------------------------------
// sot_decide: hit decision and result register
// Distance-squared compares, per-kind hit select, hit point or zero; circle-circle keeps the midpoint on a miss.
// ---------------------------------------------------------------------------
module sot_decide #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          s3_valid,
  input  logic [2*COORD_BITS-1:0]       sq_x0,
  input  logic [2*COORD_BITS-1:0]       sq_x1,
  input  logic [2*COORD_BITS-1:0]       sq_y0,
  input  logic [2*COORD_BITS-1:0]       sq_y1,
  input  logic [2*COORD_BITS-1:0]       sq_rad,
  input  sot_pkg::sot_flags_t           flags,
  input  logic [COORD_BITS-1:0]         mid_x,
  input  logic [COORD_BITS-1:0]         mid_y,
  output logic                          hit,
  output logic signed [COORD_BITS-1:0]  hit_x,
  output logic signed [COORD_BITS-1:0]  hit_y
);

  localparam int SW = 2 * COORD_BITS + 1;

  logic [SW-1:0]   rr;
  logic            c00, c10, c01, c11;
  logic            hit_nxt;
  logic [COORD_BITS-1:0] hit_x_nxt, hit_y_nxt;

  always_comb begin
    rr  = {1'b0, sq_rad};
    c00 = !flags.over[sot_pkg::OVR_X0] && !flags.over[sot_pkg::OVR_Y0] &&
          (({1'b0, sq_x0} + {1'b0, sq_y0}) <= rr);
    c10 = !flags.over[sot_pkg::OVR_X1] && !flags.over[sot_pkg::OVR_Y0] &&
          (({1'b0, sq_x1} + {1'b0, sq_y0}) <= rr);
    c01 = !flags.over[sot_pkg::OVR_X0] && !flags.over[sot_pkg::OVR_Y1] &&
          (({1'b0, sq_x0} + {1'b0, sq_y1}) <= rr);
    c11 = !flags.over[sot_pkg::OVR_X1] && !flags.over[sot_pkg::OVR_Y1] &&
          (({1'b0, sq_x1} + {1'b0, sq_y1}) <= rr);

    unique case (flags.kind) inside
      sot_pkg::KIND_BOX_BOX,
      sot_pkg::KIND_POINT_BOX:      hit_nxt = flags.direct_hit;
      sot_pkg::KIND_CIRCLE_CIRCLE,
      sot_pkg::KIND_POINT_CIRCLE:   hit_nxt = c00;
      sot_pkg::KIND_BOX_CIRCLE: begin
        // corner test only when the centre is outside both edge bands
        hit_nxt = flags.band ? flags.direct_hit : (c00 || c10 || c01 || c11);
      end
      default:                      hit_nxt = 1'b0;
    endcase

    if (hit_nxt || (flags.kind == sot_pkg::KIND_CIRCLE_CIRCLE)) begin
      hit_x_nxt = mid_x;
      hit_y_nxt = mid_y;
    end else begin
      hit_x_nxt = '0;
      hit_y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit   <= hit_nxt;
      hit_x <= hit_x_nxt;
      hit_y <= hit_y_nxt;
    end
  end

  a_unused_kind_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid && (flags.kind > sot_pkg::KIND_POINT_CIRCLE)) |-> !hit_nxt)
    else $error("unused kind produced a hit");

  a_miss_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid && !hit_nxt && (flags.kind != sot_pkg::KIND_CIRCLE_CIRCLE))
      |-> (hit_x_nxt == '0) && (hit_y_nxt == '0))
    else $error("miss carries a non-zero hit point");

  a_point_far_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid && (flags.kind == sot_pkg::KIND_POINT_CIRCLE) &&
     (flags.over[sot_pkg::OVR_X0] || flags.over[sot_pkg::OVR_Y0])) |-> !hit_nxt)
    else $error("point beyond radius on one axis reported as hit");

endmodule

@@ rtl/core/shape_overlap_test_top.sv @@
// Throughput: one request per cycle while the result side keeps taking results; no internal loop limits the rate.
// Stages: input compares, distances/midpoints, squaring, decision + output.
// A stall on out_ready backs the pipeline up stage by stage; bubbles close up.
// Reset (rst_n low, synchronous) empties the pipeline; data registers keep junk.
// ---------------------------------------------------------------------------
// shape_overlap_test_top: pipelined 2D shape-pair overlap test
// Box-box, circle-circle, box-circle, point-box and point-circle tests on
// signed Q15.8 coordinates, with hit flag and hit point per request.
// ---------------------------------------------------------------------------
module shape_overlap_test_top #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_kind,
  input  logic signed [COORD_BITS-1:0]  in_a_left,
  input  logic signed [COORD_BITS-1:0]  in_a_top,
  input  logic signed [COORD_BITS-1:0]  in_a_right,
  input  logic signed [COORD_BITS-1:0]  in_a_bottom,
  input  logic [COORD_BITS-2:0]         in_a_radius,
  input  logic signed [COORD_BITS-1:0]  in_b_left,
  input  logic signed [COORD_BITS-1:0]  in_b_top,
  input  logic signed [COORD_BITS-1:0]  in_b_right,
  input  logic signed [COORD_BITS-1:0]  in_b_bottom,
  input  logic [COORD_BITS-2:0]         in_b_radius,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic signed [COORD_BITS-1:0]  out_hit_x,
  output logic signed [COORD_BITS-1:0]  out_hit_y
);

  // --- pipeline occupancy ---------------------------------------------------
  // One valid bit per stage. A stage loads when it is empty or when the
  // stage after it is loading too, so a stall only holds full stages.
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic en1, en2, en3, en4;

  always_comb begin
    en4 = !v4_r || out_ready;
    en3 = !v3_r || en4;
    en2 = !v2_r || en3;
    en1 = !v1_r || en2;
    v1_nxt = en1 ? in_valid : v1_r;
    v2_nxt = en2 ? v1_r : v2_r;
    v3_nxt = en3 ? v2_r : v3_r;
    v4_nxt = en4 ? v3_r : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign in_ready  = en1;
  assign out_valid = v4_r;

  // --- stages 1 and 2: compares, distances, midpoints -----------------------
  logic [COORD_BITS-1:0]   mag_x0, mag_x1, mag_y0, mag_y1, radius;
  logic [COORD_BITS-1:0]   mid_x2, mid_y2, mid_x3, mid_y3;
  sot_pkg::sot_flags_t     flags2, flags3;
  logic [2*COORD_BITS-1:0] sq_x0, sq_x1, sq_y0, sq_y1, sq_rad;

  sot_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk        (clk),
    .en1        (en1),
    .en2        (en2),
    .in_kind    (in_kind),
    .in_a_left  (in_a_left),
    .in_a_top   (in_a_top),
    .in_a_right (in_a_right),
    .in_a_bottom(in_a_bottom),
    .in_a_radius(in_a_radius),
    .in_b_left  (in_b_left),
    .in_b_top   (in_b_top),
    .in_b_right (in_b_right),
    .in_b_bottom(in_b_bottom),
    .in_b_radius(in_b_radius),
    .mag_x0     (mag_x0),
    .mag_x1     (mag_x1),
    .mag_y0     (mag_y0),
    .mag_y1     (mag_y1),
    .radius     (radius),
    .flags      (flags2),
    .mid_x      (mid_x2),
    .mid_y      (mid_y2)
  );

  // --- stage 3: squares -----------------------------------------------------
  sot_square #(
    .COORD_BITS(COORD_BITS)
  ) u_square (
    .clk      (clk),
    .en       (en3),
    .mag_x0   (mag_x0),
    .mag_x1   (mag_x1),
    .mag_y0   (mag_y0),
    .mag_y1   (mag_y1),
    .radius   (radius),
    .flags_in (flags2),
    .mid_x_in (mid_x2),
    .mid_y_in (mid_y2),
    .sq_x0    (sq_x0),
    .sq_x1    (sq_x1),
    .sq_y0    (sq_y0),
    .sq_y1    (sq_y1),
    .sq_rad   (sq_rad),
    .flags_out(flags3),
    .mid_x_out(mid_x3),
    .mid_y_out(mid_y3)
  );

  // --- stage 4: decision into the output register ---------------------------
  sot_decide #(
    .COORD_BITS(COORD_BITS)
  ) u_decide (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en4),
    .s3_valid(v3_r),
    .sq_x0   (sq_x0),
    .sq_x1   (sq_x1),
    .sq_y0   (sq_y0),
    .sq_y1   (sq_y1),
    .sq_rad  (sq_rad),
    .flags   (flags3),
    .mid_x   (mid_x3),
    .mid_y   (mid_y3),
    .hit     (out_hit),
    .hit_x   (out_hit_x),
    .hit_y   (out_hit_y)
  );

  // --- checks ---------------------------------------------------------------
  a_drain_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("request refused while the result side drains");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result shown straight after reset");

  a_result_from_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v3_r))
    else $error("result appeared with no request in the squaring stage");

endmodule

@@ tb/overlap_check_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// overlap_check_pkg: request types, overlap predictor and result ledger
// Works out the hit flag and hit point of each shape-pair request and
// checks the block's results against them in arrival order.
// ---------------------------------------------------------------------------
package overlap_check_pkg;
  import sot_pkg::*;

  localparam int CB = 24;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int unsigned REPORT_CAP = 40;

  typedef struct packed {
    logic [2:0]    kind;
    logic [CB-1:0] a_left;
    logic [CB-1:0] a_top;
    logic [CB-1:0] a_right;
    logic [CB-1:0] a_bottom;
    logic [CB-2:0] a_radius;
    logic [CB-1:0] b_left;
    logic [CB-1:0] b_top;
    logic [CB-1:0] b_right;
    logic [CB-1:0] b_bottom;
    logic [CB-2:0] b_radius;
  } pair_req_t;

  typedef struct packed {
    logic          hit;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } hit_point_t;

  function automatic longint to_coord(logic [CB-1:0] v);
    return longint'($signed(v));
  endfunction

  // floor((p + q) / 2)
  function automatic longint floor_mid(longint p, longint q);
    longint s;
    s = p + q;
    return s >>> 1;
  endfunction

  function automatic longint hi_of(longint p, longint q);
    return (p > q) ? p : q;
  endfunction

  function automatic longint lo_of(longint p, longint q);
    return (p < q) ? p : q;
  endfunction

  // dx^2 + dy^2 <= r^2, exact
  function automatic bit in_radius(longint dx, longint dy, longint r);
    longint ax, ay, rr, a2, b2;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax > r || ay > r) return 1'b0;
    rr = r * r;
    a2 = ax * ax;
    b2 = ay * ay;
    return (a2 <= rr) && (b2 <= rr - a2);
  endfunction

  function automatic hit_point_t compute_overlap(pair_req_t q);
    hit_point_t res;
    longint al, at, ar, ab, ra, bl, bt, br, bb, rb, hx, hy;
    bit hit, inx, iny;
    al = to_coord(q.a_left);
    at = to_coord(q.a_top);
    ar = to_coord(q.a_right);
    ab = to_coord(q.a_bottom);
    ra = longint'(q.a_radius);
    bl = to_coord(q.b_left);
    bt = to_coord(q.b_top);
    br = to_coord(q.b_right);
    bb = to_coord(q.b_bottom);
    rb = longint'(q.b_radius);
    hit = 1'b0;
    hx = 0;
    hy = 0;
    case (q.kind)
      KIND_BOX_BOX: begin
        if (!(al > br || at > bb || ar < bl || ab < bt)) begin
          hit = 1'b1;
          hx = floor_mid(hi_of(al, bl), lo_of(ar, br));
          hy = floor_mid(hi_of(at, bt), lo_of(ab, bb));
        end
      end
      KIND_CIRCLE_CIRCLE: begin
        // centre midpoint is reported on a miss as well
        hit = in_radius(bl - al, bt - at, ra + rb);
        hx = floor_mid(al, bl);
        hy = floor_mid(at, bt);
      end
      KIND_BOX_CIRCLE: begin
        inx = (al <= bl) && (bl <= ar);
        iny = (at <= bt) && (bt <= ab);
        if (inx || iny) begin
          hit = !(al - rb > bl || at - rb > bt || ar + rb < bl || ab + rb < bt);
        end else begin
          hit = in_radius(bl - al, bt - at, rb) || in_radius(bl - ar, bt - at, rb) ||
                in_radius(bl - al, bt - ab, rb) || in_radius(bl - ar, bt - ab, rb);
        end
        if (hit) begin
          hx = floor_mid(hi_of(al, bl - rb), lo_of(ar, bl + rb));
          hy = floor_mid(hi_of(at, bt - rb), lo_of(ab, bt + rb));
        end
      end
      KIND_POINT_BOX: begin
        if (!(bl > al || bt > at || br < al || bb < at)) begin
          hit = 1'b1;
          hx = al;
          hy = at;
        end
      end
      KIND_POINT_CIRCLE: begin
        if (in_radius(al - bl, at - bt, rb)) begin
          hit = 1'b1;
          hx = al;
          hy = at;
        end
      end
      default: ;
    endcase
    res.hit = hit;
    res.x = hx[CB-1:0];
    res.y = hy[CB-1:0];
    return res;
  endfunction

  class hit_ledger;
    hit_point_t  due_hits[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned hits;

    function void note_request(pair_req_t q);
      hit_point_t e;
      e = compute_overlap(q);
      due_hits.push_back(e);
      requests++;
      if (e.hit) hits++;
    endfunction

    function void report(string what, logic signed [CB-1:0] want,
                         logic signed [CB-1:0] got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(logic hit, logic [CB-1:0] x, logic [CB-1:0] y);
      hit_point_t e;
      if (due_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, got hit %0b x %0d y %0d",
                   $time, hit, $signed(x), $signed(y));
        return;
      end
      e = due_hits.pop_front();
      if (hit !== e.hit) report("hit", {{(CB-1){1'b0}}, e.hit}, {{(CB-1){1'b0}}, hit});
      if (x !== e.x) report("hit_x", e.x, x);
      if (y !== e.y) report("hit_y", e.y, y);
    endfunction
  endclass

endpackage

@@ tb/shape_overlap_test_top_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shape_overlap_test_top_test: testbench for the shape overlap test block
// Directed edge cases then random shape pairs, with random idling on both
// channels; every result is checked in order against a local predictor.
// ---------------------------------------------------------------------------
module shape_overlap_test_top_test;
  import sot_pkg::*;
  import overlap_check_pkg::*;

  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;
  localparam int MAXR = 8388607;
  localparam int IDLE_PCT = 38;
  localparam int RANDOM_PAIRS = 1300;
  // stretch of random requests run with no idling on either side
  localparam int CALM_FIRST = 500;
  localparam int CALM_LAST = 700;
  // pipeline is 4 deep; extra wait after the last result lets stray extras show
  localparam int DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [2:0]    in_kind;
  logic [CB-1:0] in_a_left, in_a_top, in_a_right, in_a_bottom;
  logic [CB-2:0] in_a_radius;
  logic [CB-1:0] in_b_left, in_b_top, in_b_right, in_b_bottom;
  logic [CB-2:0] in_b_radius;
  logic          out_valid;
  logic          out_ready;
  logic          out_hit;
  logic [CB-1:0] out_hit_x, out_hit_y;

  hit_ledger   ledger;
  logic        calm;
  int unsigned cycles;

  shape_overlap_test_top #(
    .COORD_BITS(CB)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_a_left  (in_a_left),
    .in_a_top   (in_a_top),
    .in_a_right (in_a_right),
    .in_a_bottom(in_a_bottom),
    .in_a_radius(in_a_radius),
    .in_b_left  (in_b_left),
    .in_b_top   (in_b_top),
    .in_b_right (in_b_right),
    .in_b_bottom(in_b_bottom),
    .in_b_radius(in_b_radius),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit),
    .out_hit_x  (out_hit_x),
    .out_hit_y  (out_hit_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a missing result ends here
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: values read at the edge are the pre-edge ones, so a
  // handshake seen here is the one the block saw. Ready drops at random,
  // except during the calm stretch.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      ledger.check_result(out_hit, out_hit_x, out_hit_y);
    out_ready <= ($urandom_range(0, 99) >= (calm ? 0 : IDLE_PCT));
  end

  // Build a request; coordinates are cut to the port widths.
  function automatic pair_req_t mk(logic [2:0] kind, int al, int at, int ar, int ab,
                                   int ra, int bl, int bt, int br, int bb, int rb);
    pair_req_t q;
    q.kind = kind;
    q.a_left = al[CB-1:0];
    q.a_top = at[CB-1:0];
    q.a_right = ar[CB-1:0];
    q.a_bottom = ab[CB-1:0];
    q.a_radius = ra[CB-2:0];
    q.b_left = bl[CB-1:0];
    q.b_top = bt[CB-1:0];
    q.b_right = br[CB-1:0];
    q.b_bottom = bb[CB-1:0];
    q.b_radius = rb[CB-2:0];
    return q;
  endfunction

  function automatic int jitter(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  // Random request. Most pairs sit close together around a random origin,
  // so hits, touches and near misses are common; a few use raw full-width
  // values to toggle every bit. Boxes are occasionally inverted.
  function automatic pair_req_t rand_pair();
    int unsigned kc, mode;
    int span, ox, oy, al, at, ar, ab, ra, bl, bt, br, bb, rb;
    if ($urandom_range(0, 99) < 3)
      kc = $urandom_range(KIND_SPARE_LO, KIND_SPARE_HI);
    else
      kc = $urandom_range(KIND_BOX_BOX, KIND_POINT_CIRCLE);
    mode = $urandom_range(0, 99);
    if (mode < 12) begin
      al = int'($urandom());
      at = int'($urandom());
      ar = int'($urandom());
      ab = int'($urandom());
      ra = int'($urandom());
      bl = int'($urandom());
      bt = int'($urandom());
      br = int'($urandom());
      bb = int'($urandom());
      rb = int'($urandom());
    end else begin
      span = (mode < 60) ? 256 : ((mode < 88) ? 8192 : 262144);
      ox = int'($urandom_range(0, 16777215 - 8 * span)) - 8388608 + 4 * span;
      oy = int'($urandom_range(0, 16777215 - 8 * span)) - 8388608 + 4 * span;
      al = ox + jitter(span);
      at = oy + jitter(span);
      ar = al + int'($urandom_range(0, span));
      ab = at + int'($urandom_range(0, span));
      bl = ox + jitter(span);
      bt = oy + jitter(span);
      br = bl + int'($urandom_range(0, span));
      bb = bt + int'($urandom_range(0, span));
      if ($urandom_range(0, 99) < 6) ar = al - int'($urandom_range(1, span));
      if ($urandom_range(0, 99) < 6) bb = bt - int'($urandom_range(1, span));
      ra = int'($urandom_range(0, span));
      rb = int'($urandom_range(0, span));
    end
    return mk(kc[2:0], al, at, ar, ab, ra, bl, bt, br, bb, rb);
  endfunction

  // Present one request and hold it until taken; then maybe idle a while.
  // Valid is only lowered inside the idle loop, so a back-to-back request
  // never sees valid dropped and raised in the same step.
  task automatic drive_pair(input pair_req_t q);
    in_valid <= 1'b1;
    in_kind <= q.kind;
    in_a_left <= q.a_left;
    in_a_top <= q.a_top;
    in_a_right <= q.a_right;
    in_a_bottom <= q.a_bottom;
    in_a_radius <= q.a_radius;
    in_b_left <= q.b_left;
    in_b_top <= q.b_top;
    in_b_right <= q.b_right;
    in_b_bottom <= q.b_bottom;
    in_b_radius <= q.b_radius;
    do @(posedge clk); while (in_ready !== 1'b1);
    ledger.note_request(q);
    while ($urandom_range(0, 99) < (calm ? 0 : IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    int k;
    ledger = new();
    rst_n <= 1'b0;
    calm <= 1'b0;
    out_ready <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_BOX_BOX;
    in_a_left <= '0;
    in_a_top <= '0;
    in_a_right <= '0;
    in_a_bottom <= '0;
    in_a_radius <= '0;
    in_b_left <= '0;
    in_b_top <= '0;
    in_b_right <= '0;
    in_b_bottom <= '0;
    in_b_radius <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // box-box: overlap, shared edge, one-unit gap, full range, inverted box
    drive_pair(mk(KIND_BOX_BOX, 0, 0, 100, 100, 0, 50, 50, 200, 200, 0));
    drive_pair(mk(KIND_BOX_BOX, 0, 0, 10, 10, 0, 10, 0, 20, 10, 0));
    drive_pair(mk(KIND_BOX_BOX, 0, 0, 10, 10, 0, 11, 0, 20, 10, 0));
    drive_pair(mk(KIND_BOX_BOX, MINC, MINC, MAXC, MAXC, 0, MINC, MINC, MAXC, MAXC, 0));
    drive_pair(mk(KIND_BOX_BOX, 100, 100, 0, 0, 0, 50, 50, 60, 60, 0));
    // circle-circle: exact touch (3-4-5), just apart, far corners, zero radii
    drive_pair(mk(KIND_CIRCLE_CIRCLE, 0, 0, 0, 0, 2, 3, 4, 0, 0, 3));
    drive_pair(mk(KIND_CIRCLE_CIRCLE, 0, 0, 0, 0, 2, 3, 5, 0, 0, 3));
    drive_pair(mk(KIND_CIRCLE_CIRCLE, MINC, MINC, 0, 0, MAXR, MAXC, MAXC, 0, 0, MAXR));
    drive_pair(mk(KIND_CIRCLE_CIRCLE, MAXC, MAXC, 0, 0, 0, MAXC, MAXC, 0, 0, 0));
    // box-circle: x band touch, y band miss, corner touch, corner miss,
    // centre inside with zero radius, full-range box
    drive_pair(mk(KIND_BOX_CIRCLE, 0, 0, 100, 100, 0, 50, -20, 0, 0, 20));
    drive_pair(mk(KIND_BOX_CIRCLE, 0, 0, 100, 100, 0, 130, 50, 0, 0, 29));
    drive_pair(mk(KIND_BOX_CIRCLE, 0, 0, 100, 100, 0, 103, 104, 0, 0, 5));
    drive_pair(mk(KIND_BOX_CIRCLE, 0, 0, 100, 100, 0, 103, 105, 0, 0, 5));
    drive_pair(mk(KIND_BOX_CIRCLE, 0, 0, 100, 100, 0, 40, 60, 0, 0, 0));
    drive_pair(mk(KIND_BOX_CIRCLE, MINC, MINC, MAXC, MAXC, MAXR, MAXC, MINC, 0, 0, MAXR));
    // point-box: inside, on the corner, outside
    drive_pair(mk(KIND_POINT_BOX, 30, 40, 0, 0, 0, 0, 0, 100, 100, 0));
    drive_pair(mk(KIND_POINT_BOX, 100, 100, 0, 0, 0, 0, 0, 100, 100, 0));
    drive_pair(mk(KIND_POINT_BOX, 101, 50, 0, 0, 0, 0, 0, 100, 100, 0));
    // point-circle: inside, on the rim, just outside, opposite extremes
    drive_pair(mk(KIND_POINT_CIRCLE, 1, 1, 0, 0, 0, 0, 0, 0, 0, 5));
    drive_pair(mk(KIND_POINT_CIRCLE, 3, 4, 0, 0, 0, 0, 0, 0, 0, 5));
    drive_pair(mk(KIND_POINT_CIRCLE, 3, 5, 0, 0, 0, 0, 0, 0, 0, 5));
    drive_pair(mk(KIND_POINT_CIRCLE, MINC, MINC, 0, 0, 0, MAXC, MAXC, 0, 0, MAXR));
    // unused kind codes carry live-looking fields but must report nothing
    drive_pair(mk(KIND_SPARE_LO, 0, 0, 100, 100, 7, 50, 50, 60, 60, 7));
    drive_pair(mk(KIND_SPARE_LO + 3'd1, 0, 0, 100, 100, 7, 50, 50, 60, 60, 7));
    drive_pair(mk(KIND_SPARE_HI, MAXC, MAXC, MAXC, MAXC, MAXR, MAXC, MAXC, MAXC, MAXC, MAXR));

    for (k = 0; k < RANDOM_PAIRS; k++) begin
      calm <= (k >= CALM_FIRST && k < CALM_LAST);
      drive_pair(rand_pair());
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    // every predicted result must come back, then allow stray extras to show
    while (ledger.due_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d shape-pair requests (%0d predicted hits): edge cases, then random",
             ledger.requests, ledger.hits);
    $display("pairs over all kind codes with random and back-to-back traffic both ways.");
    if (ledger.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ shape_overlap_test_top.f @@
rtl/core/sot_pkg.sv
rtl/core/sot_geom.sv
rtl/core/sot_square.sv
rtl/core/sot_decide.sv
rtl/core/shape_overlap_test_top.sv
tb/overlap_check_pkg.sv
tb/shape_overlap_test_top_test.sv
